// File: rtl/wasm_named_section_finder_unit_assert.svh
// Assertion macros used by the section finder top level.
`ifndef WASM_NAMED_SECTION_FINDER_UNIT_ASSERT_SVH
`define WASM_NAMED_SECTION_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define WNSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define WNSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wnsf_pkg.sv
// Types and constants of the WebAssembly named section finder.
`timescale 1ns / 1ps
`default_nettype none
package wnsf_pkg;

    // Scan phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ID     = 3'd1,
        PH_SIZE   = 3'd2,
        PH_NLEN   = 3'd3,
        PH_NAME   = 3'd4,
        PH_SKIP   = 3'd5,
        PH_HOLD   = 3'd6
    } t_phase;

    // LEB128 byte outcome
    typedef enum logic [1:0] {
        LEB_MORE = 2'd0,
        LEB_DONE = 2'd1,
        LEB_BAD  = 2'd2
    } t_leb_res;

    typedef struct packed {
        t_leb_res   res;
        logic [3:0] shift;   // byte count after this byte
    } t_leb_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NAME_LEN  = 2'd0,
        CFG_NAME_LOW  = 2'd1,
        CFG_NAME_MID  = 2'd2,
        CFG_NAME_HIGH = 2'd3
    } t_cfg_reg;

    localparam int CFG_DATA_BITS = 64;
    localparam int NAME_LEN_BITS = 5;
    localparam int HDR_BYTES     = 8;
    localparam int LEB_MAX_SHIFT = 9;    // tenth byte is the last allowed
    localparam int LEB_SPAN      = 70;   // ten 7-bit groups

    typedef logic [7:0] t_byte;

    // Magic 00 61 73 6D, version 01 00 00 00
    localparam t_byte MAGIC_HDR [HDR_BYTES] = '{
        8'h00, 8'h61, 8'h73, 8'h6D, 8'h01, 8'h00, 8'h00, 8'h00
    };

endpackage
`default_nettype wire

// File: rtl/wasm_named_section_finder_unit.sv
// Top level of the WebAssembly named custom section finder.
`timescale 1ns / 1ps
`default_nettype none
// Streams a WebAssembly module in, one byte per slave transfer, tlast on the
// final byte. The first eight bytes must be the magic and version header
// 00 61 73 6D 01 00 00 00; after that the unit walks sections (id byte,
// LEB128 body size, body) and, in custom sections, decodes the LEB128 name
// length and compares the name with the programmed one. The first match is
// held. On the tlast byte one result transfer comes out: tuser is found,
// tdata carries the section's id-byte offset and its length from id byte to
// body end (both zero when not found). A match only counts when its body
// ends inside the stream. A bad header, an over-long or out-of-range size,
// or a stream longer than the offset counter ends the scan as not found.
// After each tlast byte the scan state clears; the name registers persist.
// Throughput: one byte per cycle while s_axis_tready is high; each byte updates
// the scan registers at the cost of a LEB128 group insert plus one OFFSET_BITS-wide
// add and compare. The result sits in an output register, so s_axis_tready only
// drops while that register is full and the master side stalls; it is valid in the
// cycle after the tlast transfer. The user writes configuration (name length, name
// bytes) only while idle; the block itself does not enforce it.
`include "wasm_named_section_finder_unit_assert.svh"
module wasm_named_section_finder_unit #(
    parameter int OFFSET_BITS    = 32,   // width of offsets and sizes, 16..64
    parameter int MAX_NAME_BYTES = 24    // longest name that can match, 1..24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // final_byte
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] section_offset, [63:32] section_length
    output logic [0:0]       m_axis_tuser    // [0] found
);

    localparam int NIW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam int OB  = OFFSET_BITS;

    // ---------------- configuration registers ----------------
    logic [wnsf_pkg::NAME_LEN_BITS-1:0] r_name_len;
    wnsf_pkg::t_byte                    r_name [MAX_NAME_BYTES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len <= '0;
        end else if (i_cfg_we && i_cfg_index == wnsf_pkg::CFG_NAME_LEN) begin
            r_name_len <= i_cfg_data[wnsf_pkg::NAME_LEN_BITS-1:0];
        end
    end

    // name byte k lives in register (k / 8) + 1, lane k % 8
    for (genvar k = 0; k < MAX_NAME_BYTES; k++) begin : g_name
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_name[k] <= '0;
            end else if (i_cfg_we &&
                         i_cfg_index == 2'(wnsf_pkg::CFG_NAME_LOW) + 2'(k / 8)) begin
                r_name[k] <= i_cfg_data[8 * (k % 8) +: 8];
            end
        end
    end

    // ---------------- scan state ----------------
    wnsf_pkg::t_phase                   r_phase, n_phase;
    logic [OB-1:0]                      r_byte_pos, n_byte_pos;
    logic [OB-1:0]                      r_leb_acc, n_leb_acc;
    logic [3:0]                         r_leb_shift, n_leb_shift;
    logic [OB-1:0]                      r_sect_base, n_sect_base;
    logic [OB-1:0]                      r_body_limit, n_body_limit;
    logic [wnsf_pkg::NAME_LEN_BITS-1:0] r_name_idx, n_name_idx;
    logic                               r_name_eq, n_name_eq;
    logic                               r_is_custom, n_is_custom;
    logic                               r_match_found, n_match_found;
    logic [OB-1:0]                      r_match_off, n_match_off;
    logic [OB-1:0]                      r_match_len, n_match_len;
    logic                               r_scan_aborted, n_scan_aborted;

    // result register
    logic        r_out_valid;
    logic        r_out_found, n_out_found;
    logic [31:0] r_out_off, n_out_off;
    logic [31:0] r_out_len, n_out_len;

    logic                         in_xfer;
    logic [OB-1:0]                next_pos;
    logic [OB:0]                  next_ext;
    logic                         pos_full;
    logic                         abort_now;
    logic [OB-1:0]                leb_acc_new;
    wnsf_pkg::t_leb_status        leb_stat;
    logic [OB:0]                  size_sum;
    logic [OB-1:0]                body_rem;
    logic                         nlen_ok;
    logic [wnsf_pkg::NAME_LEN_BITS-1:0] idx_inc;
    logic                         name_hit;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign next_pos  = r_byte_pos + OB'(1);
    assign next_ext  = {1'b0, r_byte_pos} + (OB + 1)'(1);
    assign pos_full  = &r_byte_pos;
    assign abort_now = r_scan_aborted || pos_full;

    wnsf_leb #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_leb (
        .i_byte   (s_axis_tdata),
        .i_shift  (r_leb_shift),
        .i_acc    (r_leb_acc),
        .o_acc    (leb_acc_new),
        .o_status (leb_stat)
    );

    // carry out flags a body end past the offset range
    assign size_sum = {1'b0, next_pos} + {1'b0, leb_acc_new};
    assign body_rem = r_body_limit - next_pos;
    assign nlen_ok  = (r_name_len <= wnsf_pkg::NAME_LEN_BITS'(MAX_NAME_BYTES))
                   && (leb_acc_new == OB'(r_name_len))
                   && (body_rem >= OB'(r_name_len));
    assign idx_inc  = r_name_idx + wnsf_pkg::NAME_LEN_BITS'(1);
    assign name_hit = r_name_eq && (s_axis_tdata == r_name[r_name_idx[NIW-1:0]]);

    // next scan state for the byte on the slave side
    always_comb begin
        n_phase        = r_phase;
        n_byte_pos     = pos_full ? r_byte_pos : next_pos;
        n_leb_acc      = r_leb_acc;
        n_leb_shift    = r_leb_shift;
        n_sect_base    = r_sect_base;
        n_body_limit   = r_body_limit;
        n_name_idx     = r_name_idx;
        n_name_eq      = r_name_eq;
        n_is_custom    = r_is_custom;
        n_match_found  = r_match_found;
        n_match_off    = r_match_off;
        n_match_len    = r_match_len;
        n_scan_aborted = abort_now;

        if (!abort_now && r_phase != wnsf_pkg::PH_HOLD) begin
            case (r_phase)
                wnsf_pkg::PH_HEADER: begin
                    if (s_axis_tdata != wnsf_pkg::MAGIC_HDR[r_byte_pos[2:0]]) begin
                        n_scan_aborted = 1'b1;
                    end else if (r_byte_pos >= OB'(wnsf_pkg::HDR_BYTES - 1)) begin
                        n_phase = wnsf_pkg::PH_ID;
                    end
                end
                wnsf_pkg::PH_ID: begin
                    n_sect_base = r_byte_pos;
                    n_is_custom = (s_axis_tdata == 8'h00);
                    n_leb_acc   = '0;
                    n_leb_shift = '0;
                    n_phase     = wnsf_pkg::PH_SIZE;
                end
                wnsf_pkg::PH_SIZE: begin
                    n_leb_acc   = leb_acc_new;
                    n_leb_shift = leb_stat.shift;
                    if (leb_stat.res == wnsf_pkg::LEB_BAD || (leb_stat.res ==
                            wnsf_pkg::LEB_DONE && size_sum[OB])) begin
                        n_scan_aborted = 1'b1;
                    end else if (leb_stat.res == wnsf_pkg::LEB_DONE) begin
                        n_body_limit = size_sum[OB-1:0];
                        if (r_is_custom && leb_acc_new != '0) begin
                            n_leb_acc   = '0;
                            n_leb_shift = '0;
                            n_phase     = wnsf_pkg::PH_NLEN;
                        end else begin
                            // empty body goes straight to the next id
                            n_phase = (leb_acc_new == '0) ? wnsf_pkg::PH_ID
                                                          : wnsf_pkg::PH_SKIP;
                        end
                    end
                end
                wnsf_pkg::PH_NLEN: begin
                    n_leb_acc   = leb_acc_new;
                    n_leb_shift = leb_stat.shift;
                    if (leb_stat.res == wnsf_pkg::LEB_MORE) begin
                        if (next_pos == r_body_limit) begin
                            n_phase = wnsf_pkg::PH_ID;
                        end
                    end else if (leb_stat.res == wnsf_pkg::LEB_DONE && nlen_ok) begin
                        if (r_name_len == '0) begin
                            n_match_found = 1'b1;
                            n_match_off   = r_sect_base;
                            n_match_len   = r_body_limit - r_sect_base;
                            n_phase       = wnsf_pkg::PH_HOLD;
                        end else begin
                            n_name_idx = '0;
                            n_name_eq  = 1'b1;
                            n_phase    = wnsf_pkg::PH_NAME;
                        end
                    end else begin
                        n_phase = (next_pos == r_body_limit) ? wnsf_pkg::PH_ID
                                                             : wnsf_pkg::PH_SKIP;
                    end
                end
                wnsf_pkg::PH_NAME: begin
                    n_name_idx = idx_inc;
                    n_name_eq  = name_hit;
                    if (idx_inc >= r_name_len) begin
                        if (name_hit) begin
                            n_match_found = 1'b1;
                            n_match_off   = r_sect_base;
                            n_match_len   = r_body_limit - r_sect_base;
                            n_phase       = wnsf_pkg::PH_HOLD;
                        end else begin
                            n_phase = (next_pos == r_body_limit) ? wnsf_pkg::PH_ID
                                                                 : wnsf_pkg::PH_SKIP;
                        end
                    end
                end
                wnsf_pkg::PH_SKIP: begin
                    if (next_pos == r_body_limit) begin
                        n_phase = wnsf_pkg::PH_ID;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result fields for a final byte
    always_comb begin
        n_out_found = n_match_found && !n_scan_aborted
                   && ({1'b0, n_body_limit} <= next_ext);
        n_out_off   = n_out_found ? 32'(n_match_off) : 32'd0;
        n_out_len   = n_out_found ? 32'(n_match_len) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_xfer && s_axis_tlast)) begin
            // final byte clears the scan for the next module
            r_phase        <= wnsf_pkg::PH_HEADER;
            r_byte_pos     <= '0;
            r_leb_acc      <= '0;
            r_leb_shift    <= '0;
            r_sect_base    <= '0;
            r_body_limit   <= '0;
            r_name_idx     <= '0;
            r_name_eq      <= 1'b1;
            r_is_custom    <= 1'b0;
            r_match_found  <= 1'b0;
            r_match_off    <= '0;
            r_match_len    <= '0;
            r_scan_aborted <= 1'b0;
        end else if (in_xfer) begin
            r_phase        <= n_phase;
            r_byte_pos     <= n_byte_pos;
            r_leb_acc      <= n_leb_acc;
            r_leb_shift    <= n_leb_shift;
            r_sect_base    <= n_sect_base;
            r_body_limit   <= n_body_limit;
            r_name_idx     <= n_name_idx;
            r_name_eq      <= n_name_eq;
            r_is_custom    <= n_is_custom;
            r_match_found  <= n_match_found;
            r_match_off    <= n_match_off;
            r_match_len    <= n_match_len;
            r_scan_aborted <= n_scan_aborted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_out_found <= n_out_found;
            r_out_off   <= n_out_off;
            r_out_len   <= n_out_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_off};
    assign m_axis_tuser  = r_out_found;

    // ---------------- assertions ----------------
    `WNSF_ASSERT_NEXT(a_final_gives_result, in_xfer && s_axis_tlast, m_axis_tvalid, "no result after final byte")
    `WNSF_ASSERT_SAME(a_miss_is_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 64'd0, "not-found result carries nonzero fields")
    `WNSF_ASSERT_SAME(a_hold_has_match, r_phase == wnsf_pkg::PH_HOLD, r_match_found, "hold phase without a match")
    `WNSF_ASSERT_NEXT(a_abort_freezes, in_xfer && !s_axis_tlast && r_scan_aborted, r_scan_aborted && $stable(r_phase), "aborted scan moved on")
    `WNSF_ASSERT_SAME(a_header_done, r_phase != wnsf_pkg::PH_HEADER, r_byte_pos >= OB'(wnsf_pkg::HDR_BYTES), "left header phase early")

endmodule
`default_nettype wire

// File: rtl/wnsf_leb.sv
// One step of an unsigned LEB128 decoder with range and length checks.
`timescale 1ns / 1ps
`default_nettype none
module wnsf_leb #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic [7:0]             i_byte,
    input  wire logic [3:0]             i_shift,
    input  wire logic [OFFSET_BITS-1:0] i_acc,
    output logic      [OFFSET_BITS-1:0] o_acc,
    output wnsf_pkg::t_leb_status       o_status
);

    logic [6:0]                      shift_amt;
    logic [wnsf_pkg::LEB_SPAN-1:0]   shifted;
    logic                            over;

    // 7 * shift without a multiplier
    assign shift_amt = {i_shift, 3'b000} - {3'b000, i_shift};
    assign shifted   = wnsf_pkg::LEB_SPAN'(i_byte[6:0]) << shift_amt;
    assign over      = |shifted[wnsf_pkg::LEB_SPAN-1:OFFSET_BITS];
    assign o_acc     = i_acc | shifted[OFFSET_BITS-1:0];

    always_comb begin
        o_status.shift = i_shift;
        if (i_shift > 4'(wnsf_pkg::LEB_MAX_SHIFT) || over) begin
            o_status.res = wnsf_pkg::LEB_BAD;
        end else if (!i_byte[7]) begin
            o_status.res = wnsf_pkg::LEB_DONE;
        end else if (i_shift == 4'(wnsf_pkg::LEB_MAX_SHIFT)) begin
            o_status.res = wnsf_pkg::LEB_BAD;
        end else begin
            o_status.res   = wnsf_pkg::LEB_MORE;
            o_status.shift = i_shift + 4'd1;
        end
    end

endmodule
`default_nettype wire
